@@ sv/sapsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sapsm_pkg;

    typedef enum logic [2:0] {
        ACT_SET_ANGLE  = 3'd0,
        ACT_SET_OFFSET = 3'd1,
        ACT_SET_PULSE  = 3'd2,
        ACT_CENTER     = 3'd3,
        ACT_TICK       = 3'd4,
        ACT_RESTART    = 3'd5
    } action_t;

    localparam logic [2:0] REG_ANGLE_MIN    = 3'd0;
    localparam logic [2:0] REG_ANGLE_CENTER = 3'd1;
    localparam logic [2:0] REG_ANGLE_MAX    = 3'd2;
    localparam logic [2:0] REG_PULSE_MIN    = 3'd3;
    localparam logic [2:0] REG_PULSE_CENTER = 3'd4;
    localparam logic [2:0] REG_PULSE_MAX    = 3'd5;
    localparam logic [2:0] REG_STEP_LIMIT   = 3'd6;
    localparam logic [2:0] REG_DIR_INVERT   = 3'd7;

    localparam logic signed [15:0] DEF_ANGLE_MIN    = 16'sd600;
    localparam logic signed [15:0] DEF_ANGLE_CENTER = 16'sd900;
    localparam logic signed [15:0] DEF_ANGLE_MAX    = 16'sd1200;
    localparam logic [15:0] DEF_PULSE_MIN    = 16'd1000;
    localparam logic [15:0] DEF_PULSE_CENTER = 16'd1500;
    localparam logic [15:0] DEF_PULSE_MAX    = 16'd2000;
    localparam logic [15:0] DEF_STEP         = 16'd20;

    localparam int QUO_W = 34;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_A2P_PREP,
        ST_A2P_MUL,
        ST_A2P_DIV,
        ST_A2P_DONE,
        ST_P2A_PREP,
        ST_P2A_MUL,
        ST_P2A_DIV,
        ST_P2A_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic a2p_prep;
        logic p2a_prep;
        logic div_start;
        logic a2p_done;
        logic p2a_done;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       div_busy;
    } sts_t;

endpackage
`default_nettype wire

@@ sv/sapsm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sapsm_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [sapsm_pkg::QUO_W-1:0]   dividend,
    input  wire logic [16:0]                   divisor,
    output logic                               busy,
    output logic [sapsm_pkg::QUO_W-1:0]        quotient
);
    localparam int CW = $clog2(sapsm_pkg::QUO_W + 1);

    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [sapsm_pkg::QUO_W-1:0]   q_reg, q_next;
    logic [17:0]                   r_reg, r_next;
    logic [16:0]                   d_reg;
    logic [17:0]                   trial;
    logic [17:0]                   diff;

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        trial = {r_reg[16:0], q_reg[sapsm_pkg::QUO_W-1]};
        diff  = trial - {1'b0, d_reg};
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        if (start)
        begin
            cnt_next = CW'(sapsm_pkg::QUO_W);
            q_next   = dividend;
            r_next   = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[17])
            begin
                r_next = diff;
                q_next = {q_reg[sapsm_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[sapsm_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= divisor;
    end

    assign busy     = (cnt_reg != '0) || start;
    assign quotient = q_reg;
endmodule
`default_nettype wire

@@ sv/sapsm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sapsm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic              out_free,
    input  wire sapsm_pkg::sts_t   sts,
    output logic                   in_ready,
    output sapsm_pkg::cmd_t        cmd
);
    sapsm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sapsm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sapsm_pkg::ST_IDLE:
                if (in_fire)
                    state_next = sapsm_pkg::ST_DECODE;
            sapsm_pkg::ST_DECODE:
                case (sts.action)
                    sapsm_pkg::ACT_SET_ANGLE, sapsm_pkg::ACT_SET_OFFSET,
                    sapsm_pkg::ACT_CENTER:
                        state_next = sapsm_pkg::ST_A2P_PREP;
                    sapsm_pkg::ACT_SET_PULSE, sapsm_pkg::ACT_TICK:
                        state_next = sapsm_pkg::ST_P2A_PREP;
                    default:
                        state_next = sapsm_pkg::ST_OUT;
                endcase
            sapsm_pkg::ST_A2P_PREP: state_next = sapsm_pkg::ST_A2P_MUL;
            sapsm_pkg::ST_A2P_MUL:  state_next = sapsm_pkg::ST_A2P_DIV;
            sapsm_pkg::ST_A2P_DIV:
                if (!sts.div_busy)
                    state_next = sapsm_pkg::ST_A2P_DONE;
            sapsm_pkg::ST_A2P_DONE: state_next = sapsm_pkg::ST_OUT;
            sapsm_pkg::ST_P2A_PREP: state_next = sapsm_pkg::ST_P2A_MUL;
            sapsm_pkg::ST_P2A_MUL:  state_next = sapsm_pkg::ST_P2A_DIV;
            sapsm_pkg::ST_P2A_DIV:
                if (!sts.div_busy)
                    state_next = sapsm_pkg::ST_P2A_DONE;
            sapsm_pkg::ST_P2A_DONE: state_next = sapsm_pkg::ST_OUT;
            sapsm_pkg::ST_OUT:
                if (out_free)
                    state_next = sapsm_pkg::ST_IDLE;
            default: state_next = sapsm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            sapsm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            sapsm_pkg::ST_A2P_PREP: cmd.a2p_prep = 1'b1;
            sapsm_pkg::ST_P2A_PREP: cmd.p2a_prep = 1'b1;
            sapsm_pkg::ST_A2P_MUL, sapsm_pkg::ST_P2A_MUL:
                cmd.div_start = 1'b1;
            sapsm_pkg::ST_A2P_DONE: cmd.a2p_done = 1'b1;
            sapsm_pkg::ST_P2A_DONE: cmd.p2a_done = 1'b1;
            sapsm_pkg::ST_OUT:      cmd.out_load = out_free;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ sv/sapsm_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sapsm_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sapsm_pkg::cmd_t   cmd,
    output sapsm_pkg::sts_t        sts,
    input  wire logic [2:0]        action,
    input  wire logic [15:0]       angle_value,
    input  wire logic [15:0]       pulse_value,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    output logic [15:0]            o_current_pulse,
    output logic [15:0]            o_current_angle,
    output logic [15:0]            o_target_pulse,
    output logic [15:0]            o_target_angle,
    output logic                   o_written
);
    logic signed [15:0] amin_reg, acen_reg, amax_reg;
    logic [15:0]        pmin_reg, pcen_reg, pmax_reg, step_reg;
    logic               inv_reg;

    logic signed [15:0] goal_a_reg, now_a_reg;
    logic [15:0]        goal_p_reg, now_p_reg;

    logic [2:0]         act_reg;
    logic signed [15:0] aval_reg;
    logic [15:0]        pval_reg;
    logic               wr_reg;

    // mapping scratch
    logic               neg_reg;      // result lies below centre
    logic [16:0]        delta_reg;
    logic [16:0]        prange_reg;   // numerator range magnitude
    logic [16:0]        drange_reg;   // divisor range
    logic               skip_reg;
    logic               p2a_goal_reg;
    logic signed [17:0] a_in_reg;     // clamped input value
    logic [15:0]        tick_p_reg;

    // effective config
    logic signed [17:0] amin, acen, amax;
    logic signed [17:0] pmin, pcen, pmax;
    logic [15:0]        step;

    always_comb
    begin
        acen = 18'(acen_reg);
        amin = (amin_reg > acen_reg) ? acen : 18'(amin_reg);
        amax = (amax_reg < acen_reg) ? acen : 18'(amax_reg);
        pcen = 18'($signed({2'b00, pcen_reg}));
        pmin = (pmin_reg > pcen_reg) ? pcen : 18'($signed({2'b00, pmin_reg}));
        pmax = (pmax_reg < pcen_reg) ? pcen : 18'($signed({2'b00, pmax_reg}));
        step = (step_reg == 16'd0) ? sapsm_pkg::DEF_STEP : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amin_reg <= sapsm_pkg::DEF_ANGLE_MIN;
            acen_reg <= sapsm_pkg::DEF_ANGLE_CENTER;
            amax_reg <= sapsm_pkg::DEF_ANGLE_MAX;
            pmin_reg <= sapsm_pkg::DEF_PULSE_MIN;
            pcen_reg <= sapsm_pkg::DEF_PULSE_CENTER;
            pmax_reg <= sapsm_pkg::DEF_PULSE_MAX;
            step_reg <= sapsm_pkg::DEF_STEP;
            inv_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sapsm_pkg::REG_ANGLE_MIN:    amin_reg <= cfg_data;
                sapsm_pkg::REG_ANGLE_CENTER: acen_reg <= cfg_data;
                sapsm_pkg::REG_ANGLE_MAX:    amax_reg <= cfg_data;
                sapsm_pkg::REG_PULSE_MIN:    pmin_reg <= cfg_data;
                sapsm_pkg::REG_PULSE_CENTER: pcen_reg <= cfg_data;
                sapsm_pkg::REG_PULSE_MAX:    pmax_reg <= cfg_data;
                sapsm_pkg::REG_STEP_LIMIT:   step_reg <= cfg_data;
                sapsm_pkg::REG_DIR_INVERT:   inv_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // angle request of the current item, before clamping
    logic signed [17:0] a_req;
    logic [15:0]        off_sum;
    always_comb
    begin
        off_sum = acen_reg + aval_reg;
        case (act_reg)
            sapsm_pkg::ACT_SET_ANGLE:  a_req = 18'(aval_reg);
            sapsm_pkg::ACT_SET_OFFSET: a_req = 18'($signed(off_sum));
            default:                   a_req = acen;
        endcase
    end

    function automatic logic signed [17:0] clamp18(logic signed [17:0] v,
                                                   logic signed [17:0] lo,
                                                   logic signed [17:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // angle-to-pulse segment setup
    logic signed [17:0] a_cl, a_m;
    logic signed [18:0] mir;
    always_comb
    begin
        a_cl = clamp18(a_req, amin, amax);
        mir  = 19'(acen) * 19'sd2 - 19'(a_cl);
        if (mir < 19'(amin))
            a_m = amin;
        else if (mir > 19'(amax))
            a_m = amax;
        else
            a_m = 18'(mir);
        if (!inv_reg)
            a_m = a_cl;
    end

    // pulse-to-angle source: goal pulse for set, stepped pulse for tick
    logic [15:0]        p_src;
    logic signed [17:0] pv_cl;
    logic signed [17:0] p_cl;
    logic [16:0]        nx;
    logic [16:0]        gs;
    logic [15:0]        tick_p;
    always_comb
    begin
        nx = {1'b0, now_p_reg} + {1'b0, step};
        gs = {1'b0, goal_p_reg} + {1'b0, step};
        tick_p = now_p_reg;
        if (now_p_reg < goal_p_reg)
            tick_p = (nx > {1'b0, goal_p_reg}) ? goal_p_reg : nx[15:0];
        else if (now_p_reg > goal_p_reg)
            tick_p = ({1'b0, now_p_reg} <= gs) ? goal_p_reg : now_p_reg - step;
        pv_cl = clamp18(18'($signed({2'b00, pval_reg})), pmin, pmax);
        p_src = (act_reg == sapsm_pkg::ACT_TICK) ? tick_p : pv_cl[15:0];
        p_cl = clamp18(18'($signed({2'b00, p_src})), pmin, pmax);
    end

    logic        div_busy;
    logic [33:0] quo;
    logic [33:0] prod;

    sapsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod),
        .divisor  (drange_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    logic signed [18:0] res_p;
    logic signed [17:0] res_p_cl;
    logic signed [19:0] res_a;
    logic signed [17:0] res_a_cl;
    always_comb
    begin
        prod  = {17'd0, delta_reg} * {17'd0, prange_reg};
        res_p = neg_reg ? 19'(pcen) - 19'($signed({2'b00, quo[16:0]}))
                        : 19'(pcen) + 19'($signed({2'b00, quo[16:0]}));
        if (skip_reg)
            res_p = 19'(pcen);
        res_p_cl = clamp18(18'(res_p), pmin, pmax);
        res_a = neg_reg ? 20'(acen) - 20'($signed({3'b000, quo[16:0]}))
                        : 20'(acen) + 20'($signed({3'b000, quo[16:0]}));
        if (skip_reg)
            res_a = 20'(acen);
        if (inv_reg)
            res_a = 20'(acen) * 20'sd2 - res_a;
        if (res_a < 20'(amin))
            res_a_cl = amin;
        else if (res_a > 20'(amax))
            res_a_cl = amax;
        else
            res_a_cl = 18'(res_a);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            aval_reg <= angle_value;
            pval_reg <= pulse_value;
        end
        if (cmd.a2p_prep)
        begin
            a_in_reg <= a_cl;
            if (a_m >= acen)
            begin
                neg_reg    <= 1'b0;
                delta_reg  <= 17'(a_m - acen);
                drange_reg <= 17'(amax - acen);
                prange_reg <= 17'(pmax - pcen);
                skip_reg   <= (amax == acen);
            end
            else
            begin
                neg_reg    <= 1'b1;
                delta_reg  <= 17'(acen - a_m);
                drange_reg <= 17'(acen - amin);
                prange_reg <= 17'(pcen - pmin);
                skip_reg   <= (acen == amin);
            end
        end
        if (cmd.p2a_prep)
        begin
            tick_p_reg   <= p_src;
            p2a_goal_reg <= (act_reg != sapsm_pkg::ACT_TICK);
            if (p_cl >= pcen)
            begin
                neg_reg    <= 1'b0;
                delta_reg  <= 17'(p_cl - pcen);
                drange_reg <= 17'(pmax - pcen);
                prange_reg <= 17'(amax - acen);
                skip_reg   <= (pmax == pcen);
            end
            else
            begin
                neg_reg    <= 1'b1;
                delta_reg  <= 17'(pcen - p_cl);
                drange_reg <= 17'(pcen - pmin);
                prange_reg <= 17'(acen - amin);
                skip_reg   <= (pcen == pmin);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_a_reg <= sapsm_pkg::DEF_ANGLE_CENTER;
            now_a_reg  <= sapsm_pkg::DEF_ANGLE_CENTER;
            goal_p_reg <= sapsm_pkg::DEF_PULSE_CENTER;
            now_p_reg  <= sapsm_pkg::DEF_PULSE_CENTER;
            wr_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                wr_reg <= (action == sapsm_pkg::ACT_TICK) ||
                          (action == sapsm_pkg::ACT_RESTART);
                if (action == sapsm_pkg::ACT_RESTART)
                begin
                    goal_a_reg <= acen_reg;
                    now_a_reg  <= acen_reg;
                    goal_p_reg <= pcen_reg;
                    now_p_reg  <= pcen_reg;
                end
            end
            if (cmd.a2p_done)
            begin
                goal_a_reg <= a_in_reg[15:0];
                goal_p_reg <= res_p_cl[15:0];
            end
            if (cmd.p2a_done)
            begin
                if (p2a_goal_reg)
                begin
                    goal_p_reg <= tick_p_reg;
                    goal_a_reg <= res_a_cl[15:0];
                end
                else
                begin
                    now_p_reg <= tick_p_reg;
                    now_a_reg <= res_a_cl[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_current_pulse <= now_p_reg;
            o_current_angle <= now_a_reg;
            o_target_pulse  <= goal_p_reg;
            o_target_angle  <= goal_a_reg;
            o_written       <= wr_reg;
        end
    end

    assign sts.action   = act_reg;
    assign sts.div_busy = div_busy;
endmodule
`default_nettype wire

@@ sv/servo_angle_pulse_slew_mapper.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel      Dir  Beat contents
// s_axis       in   action, angle_value, pulse_value
// m_axis       out  current_pulse, current_angle, target_pulse, target_angle, pulse_written
// cfg          in   register write (index, data)
// One item at a time: restart and unused actions go from decode straight to output;
// angle, offset, pulse and tick also pass through the multiply and the bit-serial divider.
// The result register frees the controller, so the next item is taken while the
// previous result waits, one result deep. Reset loads config, position, valid and control state at once.
module servo_angle_pulse_slew_mapper (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // action[2:0], angle_value[18:3], pulse_value[34:19]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // current_pulse, current_angle, target_pulse,
                                            // target_angle, pulse_written[64]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    sapsm_pkg::cmd_t cmd;
    sapsm_pkg::sts_t sts;
    logic            in_fire;
    logic            out_free;
    logic            vld_reg;
    logic [15:0]     cp, ca, tp, ta;
    logic            wr;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !vld_reg || m_axis_tready;

    sapsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    sapsm_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .action          (s_axis_tdata[2:0]),
        .angle_value     (s_axis_tdata[18:3]),
        .pulse_value     (s_axis_tdata[34:19]),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .o_current_pulse (cp),
        .o_current_angle (ca),
        .o_target_pulse  (tp),
        .o_target_angle  (ta),
        .o_written       (wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (cmd.out_load)
            vld_reg <= 1'b1;
        else if (m_axis_tready)
            vld_reg <= 1'b0;
    end

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = {7'd0, wr, ta, tp, ca, cp};
endmodule
`default_nettype wire

@@ sv/sapsm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sapsm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata
);
    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // no new item is taken in the cycle after one is accepted
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

    // padding bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:65] == 7'd0)
        else $error("padding not zero");
endmodule

bind servo_angle_pulse_slew_mapper sapsm_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
